// File: rtl/e2m_pkg.sv
// Shared constants, types and microprogram for the Elligator 2 map unit.
package e2m_pkg;

	localparam int unsigned FE_W   = 256;
	localparam int unsigned ACC_W  = 289;
	localparam int unsigned ADDR_W = 3;

	localparam logic [FE_W-1:0] P_MOD    = {1'b0, {250{1'b1}}, 5'b01101};
	localparam logic [FE_W-1:0] P_MINUS2 = {1'b0, {250{1'b1}}, 5'b01011};
	localparam logic [FE_W-1:0] HALF_PM1 = {2'b00, {250{1'b1}}, 4'b0110};
	localparam logic [FE_W+1:0] FOUR_P   = {P_MOD, 2'b00};
	localparam logic [FE_W-1:0] A_COEF   = 256'd486662;
	localparam logic [5:0]      FOLD_K   = 6'd38;

	// ALU and sequencer operation codes
	localparam logic [2:0] OP_MUL   = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_SUB   = 3'd2;
	localparam logic [2:0] OP_NEG   = 3'd3;
	localparam logic [2:0] OP_CANON = 3'd4;
	localparam logic [2:0] OP_SEL   = 3'd5;
	localparam logic [2:0] OP_POW   = 3'd6;

	// second operand source
	localparam logic [1:0] IMM_NONE = 2'd0;
	localparam logic [1:0] IMM_ONE  = 2'd1;
	localparam logic [1:0] IMM_A    = 2'd2;

	// register file entries
	localparam logic [ADDR_W-1:0] M_R = 3'd0;
	localparam logic [ADDR_W-1:0] M_T = 3'd1;
	localparam logic [ADDR_W-1:0] M_V = 3'd2;
	localparam logic [ADDR_W-1:0] M_E = 3'd3;
	localparam logic [ADDR_W-1:0] M_X = 3'd4;

	localparam logic [3:0] PC_LAST  = 4'd15;
	localparam logic [3:0] MUL_LAST = 4'd8;
	localparam logic [7:0] POW_TOP  = 8'd254;

	typedef struct packed {
		logic [2:0]        op;
		logic [ADDR_W-1:0] dst;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [1:0]        bimm;
		logic              esel;
	} instr_t;

	typedef struct packed {
		logic [2:0] op;
		logic       exec;
		logic       fold;
		logic [3:0] cnt;
	} alu_ctl_t;

	function automatic instr_t prog(input logic [3:0] pc);
		instr_t i;
		case (pc)
			4'd0:  i = instr_t'{OP_MUL,   M_T, M_R, M_R, IMM_NONE, 1'b0};
			4'd1:  i = instr_t'{OP_ADD,   M_T, M_T, M_T, IMM_NONE, 1'b0};
			4'd2:  i = instr_t'{OP_ADD,   M_T, M_T, M_T, IMM_ONE,  1'b0};
			4'd3:  i = instr_t'{OP_POW,   M_V, M_T, M_T, IMM_NONE, 1'b0};
			4'd4:  i = instr_t'{OP_MUL,   M_V, M_V, M_V, IMM_A,    1'b0};
			4'd5:  i = instr_t'{OP_NEG,   M_V, M_V, M_V, IMM_NONE, 1'b0};
			4'd6:  i = instr_t'{OP_ADD,   M_E, M_V, M_V, IMM_A,    1'b0};
			4'd7:  i = instr_t'{OP_MUL,   M_E, M_E, M_V, IMM_NONE, 1'b0};
			4'd8:  i = instr_t'{OP_ADD,   M_E, M_E, M_E, IMM_ONE,  1'b0};
			4'd9:  i = instr_t'{OP_MUL,   M_E, M_E, M_V, IMM_NONE, 1'b0};
			4'd10: i = instr_t'{OP_POW,   M_T, M_E, M_E, IMM_NONE, 1'b1};
			4'd11: i = instr_t'{OP_CANON, M_T, M_T, M_T, IMM_NONE, 1'b0};
			4'd12: i = instr_t'{OP_NEG,   M_X, M_V, M_V, IMM_NONE, 1'b0};
			4'd13: i = instr_t'{OP_SUB,   M_X, M_X, M_X, IMM_A,    1'b0};
			4'd14: i = instr_t'{OP_SEL,   M_X, M_V, M_X, IMM_NONE, 1'b0};
			default: i = instr_t'{OP_CANON, M_X, M_X, M_X, IMM_NONE, 1'b0};
		endcase
		return i;
	endfunction

	function automatic logic exp_bit(input logic esel, input logic [7:0] idx);
		logic [FE_W-1:0] e;
		e = esel ? HALF_PM1 : P_MINUS2;
		return e[idx];
	endfunction

endpackage

// File: rtl/elligator2_map_to_curve_unit.sv
// Top level: input buffer, microcoded sequencer, register file, arithmetic unit, output register.
//
// Usage
//   Input channel: r_limb0..r_limb3 with in_valid / in_stall. A transaction is taken when
//   in_valid is high and in_stall is low. One transaction is buffered while the previous
//   representative is still being mapped, so a new r can be taken during computation.
//   Output channel: x_limb0..x_limb3, in_range with out_valid / out_stall. The result sits
//   in an output register until taken; the next computation runs on meanwhile and waits in
//   its final state only if that register is still occupied.
//   The work is set by the single arithmetic unit: a field multiply is a read step, eight
//   256x32 word steps plus a drain step, the two fold states and a write-back step, and the
//   two fixed exponentiations take 1015 multiplies. Other field operations pass once through
//   the read, execute, fold and write-back states.
//   Items are processed one after another; results come out in input order.
//   Reset: arst_n clears the control state; the block is idle, holds no transaction and
//   accepts input as soon as reset is released. Operand storage needs no clearing.
//   Stall: while out_stall holds a result, at most one more result is finished and held
//   back, and one further input transaction is buffered; then in_stall rises.
module elligator2_map_to_curve_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] r_limb0,
	input  logic [63:0] r_limb1,
	input  logic [63:0] r_limb2,
	input  logic [63:0] r_limb3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] x_limb0,
	output logic [63:0] x_limb1,
	output logic [63:0] x_limb2,
	output logic [62:0] x_limb3,
	output logic        in_range
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LDR   = 4'd1;
	localparam logic [3:0] S_PINIT = 4'd2;
	localparam logic [3:0] S_FETCH = 4'd3;
	localparam logic [3:0] S_EXEC  = 4'd4;
	localparam logic [3:0] S_FOLD1 = 4'd5;
	localparam logic [3:0] S_FOLD2 = 4'd6;
	localparam logic [3:0] S_WRITE = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]                      state_q;
	logic [3:0]                      pc_q;
	logic [3:0]                      cnt_q;
	logic [7:0]                      pow_bit_q;
	logic                            phase_q;
	logic                            buf_valid_q;
	logic [255:0]                    buf_r_q;
	logic                            buf_range_q;
	logic                            range_q;
	logic                            out_valid_q;
	logic [254:0]                    x_q;
	logic                            out_range_q;

	e2m_pkg::instr_t                 ins;
	e2m_pkg::instr_t                 nxt_ins;
	e2m_pkg::alu_ctl_t               ctl;
	logic [2:0]                      alu_op;
	logic                            is_pow;
	logic                            ebit;
	logic [255:0]                    r_in;
	logic                            in_acc;
	logic                            out_load;
	logic                            we;
	logic [e2m_pkg::ADDR_W-1:0]      waddr;
	logic [255:0]                    wdata;
	logic [e2m_pkg::ADDR_W-1:0]      raddr_a;
	logic [e2m_pkg::ADDR_W-1:0]      raddr_b;
	logic [255:0]                    rdata_a;
	logic [255:0]                    rdata_b;
	logic [255:0]                    opb;
	logic [255:0]                    alu_res;
	logic                            alu_one;

	assign ins     = e2m_pkg::prog(pc_q);
	assign nxt_ins = e2m_pkg::prog(4'(pc_q + 4'd1));
	assign is_pow  = (ins.op == e2m_pkg::OP_POW);
	assign alu_op  = is_pow ? e2m_pkg::OP_MUL : ins.op;
	assign ebit    = e2m_pkg::exp_bit(ins.esel, pow_bit_q);

	assign r_in     = {r_limb3, r_limb2, r_limb1, r_limb0};
	assign in_stall = buf_valid_q;
	assign in_acc   = in_valid && !buf_valid_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// exponentiation: square into dst, then multiply dst by the base when the bit is set
	assign raddr_a = is_pow ? ins.dst : ins.a;
	assign raddr_b = is_pow ? (phase_q ? ins.a : ins.dst) : ins.b;

	always_comb begin
		case (ins.bimm)
			e2m_pkg::IMM_ONE: opb = 256'd1;
			e2m_pkg::IMM_A:   opb = e2m_pkg::A_COEF;
			default:          opb = rdata_b;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = ins.dst;
		wdata = alu_res;
		case (state_q)
			S_LDR: begin
				we    = 1'b1;
				waddr = e2m_pkg::M_R;
				wdata = buf_r_q;
			end
			S_PINIT: begin
				we    = 1'b1;
				wdata = 256'd1;
			end
			S_WRITE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign ctl.op   = alu_op;
	assign ctl.exec = (state_q == S_EXEC);
	assign ctl.fold = (state_q == S_FOLD1) || (state_q == S_FOLD2);
	assign ctl.cnt  = cnt_q;

	e2m_regfile u_regfile (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (state_q == S_FETCH),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	e2m_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (rdata_a),
		.opb    (opb),
		.result (alu_res),
		.is_one (alu_one)
	);

	// input buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (in_acc) begin
			buf_valid_q <= 1'b1;
		end else if (state_q == S_IDLE) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_r_q     <= r_in;
			buf_range_q <= (r_in <= e2m_pkg::HALF_PM1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			cnt_q     <= '0;
			pow_bit_q <= '0;
			phase_q   <= 1'b0;
			range_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (buf_valid_q) begin
						range_q <= buf_range_q;
						pc_q    <= '0;
						state_q <= S_LDR;
					end
				end
				S_LDR: begin
					state_q <= S_FETCH;
				end
				S_PINIT: begin
					pow_bit_q <= e2m_pkg::POW_TOP;
					phase_q   <= 1'b0;
					state_q   <= S_FETCH;
				end
				S_FETCH: begin
					cnt_q   <= '0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					cnt_q <= 4'(cnt_q + 4'd1);
					if (alu_op != e2m_pkg::OP_MUL || cnt_q == e2m_pkg::MUL_LAST) begin
						state_q <= S_FOLD1;
					end
				end
				S_FOLD1: begin
					state_q <= S_FOLD2;
				end
				S_FOLD2: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (is_pow && !phase_q && ebit) begin
						phase_q <= 1'b1;
						state_q <= S_FETCH;
					end else if (is_pow && pow_bit_q != 8'd0) begin
						pow_bit_q <= 8'(pow_bit_q - 8'd1);
						phase_q   <= 1'b0;
						state_q   <= S_FETCH;
					end else if (pc_q == e2m_pkg::PC_LAST) begin
						state_q <= S_DONE;
					end else begin
						pc_q    <= 4'(pc_q + 4'd1);
						state_q <= (nxt_ins.op == e2m_pkg::OP_POW) ? S_PINIT : S_FETCH;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			x_q         <= alu_res[254:0];
			out_range_q <= range_q;
		end
	end

	assign out_valid = out_valid_q;
	assign x_limb0   = x_q[63:0];
	assign x_limb1   = x_q[127:64];
	assign x_limb2   = x_q[191:128];
	assign x_limb3   = x_q[254:192];
	assign in_range  = out_range_q;

	// the final canonical value never reaches p, so bit 255 is clear at hand-off
	a_result_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (alu_res[255] == 1'b0))
		else $error("result not reduced at hand-off");

	a_ldr_to_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LDR) |=> (state_q == S_FETCH && pc_q == 4'd0))
		else $error("sequence did not start at first instruction");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> (cnt_q <= e2m_pkg::MUL_LAST))
		else $error("multiply step count overrun");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result presented outside done state");

	a_pow_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH && is_pow) |-> (pow_bit_q <= e2m_pkg::POW_TOP))
		else $error("exponent bit index out of range");

	a_one_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && ins.op == e2m_pkg::OP_SEL) |-> $stable(alu_one))
		else $error("square flag changed during select");

endmodule

// File: rtl/e2m_regfile.sv
// Field element register file: one write port, two registered read ports.
module e2m_regfile (
	input  logic                         clk,
	input  logic                         we,
	input  logic [e2m_pkg::ADDR_W-1:0]   waddr,
	input  logic [e2m_pkg::FE_W-1:0]     wdata,
	input  logic                         re,
	input  logic [e2m_pkg::ADDR_W-1:0]   raddr_a,
	input  logic [e2m_pkg::ADDR_W-1:0]   raddr_b,
	output logic [e2m_pkg::FE_W-1:0]     rdata_a,
	output logic [e2m_pkg::FE_W-1:0]     rdata_b
);

	logic [e2m_pkg::FE_W-1:0] mem [2**e2m_pkg::ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: rtl/e2m_alu.sv
// Modular arithmetic unit: word-serial multiply, add, subtract, negate, select, fold, canonical reduction.
module e2m_alu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  e2m_pkg::alu_ctl_t         ctl,
	input  logic [e2m_pkg::FE_W-1:0]  opa,
	input  logic [e2m_pkg::FE_W-1:0]  opb,
	output logic [e2m_pkg::FE_W-1:0]  result,
	output logic                      is_one
);

	localparam int unsigned AW = e2m_pkg::ACC_W;

	logic [AW-1:0]            acc_q;
	logic [63:0]              pp_s1 [8];
	logic                     one_q;
	logic [2:0]               widx;
	logic [31:0]              bword;
	logic [255:0]             ev;
	logic [255:0]             od;
	logic [AW-1:0]            mul_sum;
	logic [AW-1:0]            fold_next;
	logic [AW-1:0]            canon_next;

	// most significant word of b first
	assign widx  = ~ctl.cnt[2:0];
	assign bword = opb[widx*32 +: 32];

	// partial products at even and odd word offsets do not overlap
	assign ev = {pp_s1[6], pp_s1[4], pp_s1[2], pp_s1[0]};
	assign od = {pp_s1[7], pp_s1[5], pp_s1[3], pp_s1[1]};

	// acc * 2^32 with the bits above 2^256 folded back as times 38
	assign mul_sum = AW'({acc_q[223:0], 32'b0})
		+ AW'(acc_q[288:224]) * AW'(e2m_pkg::FOLD_K)
		+ AW'(ev) + AW'({od, 32'b0});

	assign fold_next = AW'(acc_q[255:0]) + AW'(acc_q[288:256]) * AW'(e2m_pkg::FOLD_K);

	assign canon_next = (acc_q[255:0] >= e2m_pkg::P_MOD) ?
		AW'(acc_q[255:0] - e2m_pkg::P_MOD) : AW'(acc_q[255:0]);

	always_ff @(posedge clk) begin
		if (ctl.exec && ctl.op == e2m_pkg::OP_MUL && ctl.cnt < e2m_pkg::MUL_LAST) begin
			for (int i = 0; i < 8; i++) begin
				pp_s1[i] <= opa[i*32 +: 32] * bword;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			case (ctl.op)
				e2m_pkg::OP_MUL: begin
					if (ctl.cnt == 4'd0) begin
						acc_q <= '0;
					end else begin
						acc_q <= mul_sum;
					end
				end
				e2m_pkg::OP_ADD:   acc_q <= AW'(opa) + AW'(opb);
				e2m_pkg::OP_SUB:   acc_q <= AW'(opa) + AW'(e2m_pkg::FOUR_P) - AW'(opb);
				e2m_pkg::OP_NEG:   acc_q <= AW'(e2m_pkg::FOUR_P) - AW'(opa);
				e2m_pkg::OP_SEL:   acc_q <= one_q ? AW'(opa) : AW'(opb);
				e2m_pkg::OP_CANON: acc_q <= AW'(opa);
				default:           acc_q <= acc_q;
			endcase
		end else if (ctl.fold) begin
			if (ctl.op == e2m_pkg::OP_CANON) begin
				acc_q <= canon_next;
			end else begin
				acc_q <= fold_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_q <= 1'b0;
		end else if (ctl.fold && ctl.op == e2m_pkg::OP_CANON) begin
			one_q <= (canon_next == AW'(1));
		end
	end

	assign result = acc_q[255:0];
	assign is_one = one_q;

endmodule

// File: tb/elligator2_map_to_curve_unit_test.sv
// Self-checking testbench for the Elligator 2 map-to-curve unit.
module elligator2_map_to_curve_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM     = 278;
	localparam int HOLDOFF_LEN  = 40000;
	localparam int WATCHDOG_MAX = 200000;

	typedef struct {
		logic [255:0] r;
		bit           drain_first;
	} rep_item_t;

	typedef struct {
		logic [254:0] x;
		logic         in_range;
	} curve_x_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] r_limb0, r_limb1, r_limb2, r_limb3;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] x_limb0, x_limb1, x_limb2;
	logic [62:0] x_limb3;
	logic        in_range;

	rep_item_t pending_reps[$];
	curve_x_t  expected_x[$];
	int        n_accepted;
	int        n_results;
	int        n_in_range;
	int        n_errors;
	int        holdoff_left;
	bit        holdoff_done;
	int        idle_cycles;

	elligator2_map_to_curve_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.r_limb0(r_limb0), .r_limb1(r_limb1), .r_limb2(r_limb2), .r_limb3(r_limb3),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_limb0(x_limb0), .x_limb1(x_limb1), .x_limb2(x_limb2), .x_limb3(x_limb3),
		.in_range(in_range)
	);

	function automatic logic [255:0] gf_mul(input logic [255:0] a, input logic [255:0] b);
		logic [511:0] prod;
		prod = {256'b0, a} * {256'b0, b};
		prod = prod % {256'b0, e2m_pkg::P_MOD};
		return prod[255:0];
	endfunction

	function automatic logic [255:0] gf_add(input logic [255:0] a, input logic [255:0] b);
		logic [257:0] s;
		s = ({2'b0, a} + {2'b0, b}) % {2'b0, e2m_pkg::P_MOD};
		return s[255:0];
	endfunction

	function automatic logic [255:0] gf_pow(input logic [255:0] a, input logic [255:0] ex);
		logic [255:0] acc;
		acc = 256'd1;
		for (int i = 254; i >= 0; i--) begin
			acc = gf_mul(acc, acc);
			if (ex[i])
				acc = gf_mul(acc, a);
		end
		return acc;
	endfunction

	// v = -A/(1+2r^2); keep v on a nonzero square e = v^3+Av^2+v, else take -v-A
	function automatic curve_x_t map_representative(input logic [255:0] r);
		curve_x_t     res;
		logic [255:0] rr, den, v, e, leg;
		logic [257:0] alt;
		rr  = r % e2m_pkg::P_MOD;
		den = gf_add(gf_add(gf_mul(rr, rr), gf_mul(rr, rr)), 256'd1);
		v   = gf_mul(gf_pow(den, e2m_pkg::P_MINUS2), e2m_pkg::A_COEF);
		v   = (v == 0) ? 256'd0 : e2m_pkg::P_MOD - v;
		e   = gf_mul(gf_add(gf_mul(gf_add(v, e2m_pkg::A_COEF), v), 256'd1), v);
		leg = gf_pow(e, e2m_pkg::HALF_PM1);
		alt = ({2'b0, e2m_pkg::P_MOD} + {2'b0, e2m_pkg::P_MOD} - {2'b0, v}
			- {2'b0, e2m_pkg::A_COEF}) % {2'b0, e2m_pkg::P_MOD};
		res.x        = (leg == 256'd1) ? v[254:0] : alt[254:0];
		res.in_range = (r <= e2m_pkg::HALF_PM1);
		return res;
	endfunction

	task automatic report(input string field, input logic [254:0] exp_v, input logic [254:0] got);
		$display("MISMATCH result %0d %s: expected %h got %h", n_results, field, exp_v, got);
		n_errors++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: gaps about 12 percent except in a quiet stretch
	always @(posedge clk or negedge arst_n) begin
		rep_item_t nxt;
		bit        gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			{r_limb3, r_limb2, r_limb1, r_limb0} <= '0;
			n_accepted <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_x.push_back(map_representative({r_limb3, r_limb2, r_limb1, r_limb0}));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				gap = ($urandom_range(99) < 12) && !(n_accepted >= 100 && n_accepted < 160);
				if (pending_reps.size() > 0 && !gap &&
				    !(pending_reps[0].drain_first &&
				      (in_valid || n_results != n_accepted))) begin
					nxt = pending_reps.pop_front();
					in_valid <= 1'b1;
					{r_limb3, r_limb2, r_limb1, r_limb0} <= nxt.r;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off, compare each transaction
	always @(posedge clk or negedge arst_n) begin
		curve_x_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			n_results <= 0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_x.size() == 0) begin
					report("unexpected", 255'd0, {x_limb3, x_limb2, x_limb1, x_limb0});
				end else begin
					want = expected_x.pop_front();
					if (want.x[254:192] !== x_limb3)
						report("x_limb3", 255'(want.x[254:192]), 255'(x_limb3));
					if (want.x[191:128] !== x_limb2)
						report("x_limb2", 255'(want.x[191:128]), 255'(x_limb2));
					if (want.x[127:64] !== x_limb1)
						report("x_limb1", 255'(want.x[127:64]), 255'(x_limb1));
					if (want.x[63:0] !== x_limb0)
						report("x_limb0", 255'(want.x[63:0]), 255'(x_limb0));
					if (want.in_range !== in_range)
						report("in_range", 255'(want.in_range), 255'(in_range));
					if (in_range === 1'b1) n_in_range++;
				end
				n_results <= n_results + 1;
			end
			if (!holdoff_done && n_results == 30) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_LEN;
				out_stall <= 1'b1;
			end else if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < 12) && !(n_results >= 100 && n_results < 160);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_MAX);
			$display("elligator2_map_to_curve_unit test failed");
			$finish;
		end
	end

	task automatic add_rep(input logic [255:0] r, input bit drain_first);
		rep_item_t it;
		it.r = r;
		it.drain_first = drain_first;
		pending_reps.push_back(it);
	endtask

	initial begin
		logic [255:0] r;
		n_errors = 0;
		n_in_range = 0;
		idle_cycles = 0;
		arst_n = 1'b0;

		// zero, one, two, range boundary, modulus edges, all ones, top bit only, alternating bits
		add_rep(256'd0, 1'b0);
		add_rep(256'd1, 1'b0);
		add_rep(256'd2, 1'b0);
		add_rep(e2m_pkg::HALF_PM1, 1'b0);
		add_rep(e2m_pkg::HALF_PM1 - 1, 1'b0);
		add_rep(e2m_pkg::HALF_PM1 + 1, 1'b0);
		add_rep(e2m_pkg::P_MOD - 1, 1'b0);
		add_rep(e2m_pkg::P_MOD, 1'b0);
		add_rep(e2m_pkg::P_MOD + 1, 1'b0);
		add_rep({256{1'b1}}, 1'b0);
		add_rep({1'b1, 255'b0}, 1'b0);
		add_rep({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
		         64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			r = {rand64(), rand64(), rand64(), rand64()};
			case ($urandom_range(3))
				0: r[255:64] = {e2m_pkg::HALF_PM1[255:65], 1'($urandom_range(1))};
				1: r[255:64] = {e2m_pkg::P_MOD[255:65], 1'($urandom_range(1))};
				2: r[255] = 1'b0;
				default: ;
			endcase
			add_rep(r, i == 60 || i == 200);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reps.size() == 0 && !in_valid);
		wait (n_results == n_accepted);
		repeat (200) @(posedge clk);

		$display("mapped %0d representatives, %0d within (p-1)/2, with stalls and a long hold-off",
		         n_results, n_in_range);
		if (n_errors == 0 && expected_x.size() == 0) begin
			$display("elligator2_map_to_curve_unit test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, expected_x.size());
			$display("elligator2_map_to_curve_unit test failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/e2m_pkg.sv
rtl/e2m_regfile.sv
rtl/e2m_alu.sv
rtl/elligator2_map_to_curve_unit.sv
tb/elligator2_map_to_curve_unit_test.sv
